// ----- rtl/gwps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwps_pkg
// Shared widths, codes and control types of the geometric weighted position
// smoother.
// ----------------------------------------------------------------------------
package gwps_pkg;

   // Default sizing
   localparam int MAX_LEVEL_DEF        = 16;
   localparam int WEIGHT_FRAC_BITS_DEF = 16;

   // Field widths
   localparam int POS_W      = 16;
   localparam int MODE_W     = 2;
   localparam int LEVEL_W    = 5;
   localparam int MULT_W     = 17;
   localparam int FILTER_W   = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;
   localparam int QUO_W      = 16;          // average magnitude fits 16 bits
   localparam int DIFF_W     = POS_W + 1;   // position difference
   localparam int MUL_FRAC_BITS = 16;       // ratio is Q1.16

   // Register reset values
   localparam logic [LEVEL_W-1:0]  LEVEL_RESET  = 5'd8;
   localparam logic [MULT_W-1:0]   MULT_RESET   = 17'd49152;
   localparam logic [FILTER_W-1:0] FILTER_RESET = 17'd2;
   localparam logic [MULT_W-1:0]   MULT_ONE     = 17'd65536;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MULTIPLIER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER     = 2'd2;

   // Input kinds
   localparam logic [MODE_W-1:0] MODE_BYPASS  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TOUCH   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

   // Multiply-accumulate operations
   localparam logic [1:0] MAC_NOP   = 2'd0;
   localparam logic [1:0] MAC_MUL_X = 2'd1;   // weight * x, add weight to sum
   localparam logic [1:0] MAC_MUL_Y = 2'd2;   // weight * y, accumulate x term
   localparam logic [1:0] MAC_MUL_W = 2'd3;   // weight * ratio, accumulate y term

   // History line operations
   localparam logic [1:0] HIST_HOLD   = 2'd0;
   localparam logic [1:0] HIST_FILL   = 2'd1;
   localparam logic [1:0] HIST_PUSH   = 2'd2;
   localparam logic [1:0] HIST_ROTATE = 2'd3;

   typedef struct packed {
      logic       clear;
      logic       first;
      logic [1:0] op;
   } mac_ctrl_type;

   typedef struct packed {
      logic [1:0] op;
   } hist_ctrl_type;

endpackage

// ----- rtl/gwps_hist.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwps_hist
// Position history line: hold, fill, push at the head, or rotate so that each
// entry passes the head once per full turn.
// ----------------------------------------------------------------------------
module gwps_hist #(
   parameter int MAX_LEVEL = gwps_pkg::MAX_LEVEL_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  gwps_pkg::hist_ctrl_type           ctrl,
   input  logic signed [gwps_pkg::POS_W-1:0] in_x,
   input  logic signed [gwps_pkg::POS_W-1:0] in_y,
   output logic signed [gwps_pkg::POS_W-1:0] head_x,
   output logic signed [gwps_pkg::POS_W-1:0] head_y
);

   logic signed [gwps_pkg::POS_W-1:0] hx_ff [MAX_LEVEL];
   logic signed [gwps_pkg::POS_W-1:0] hy_ff [MAX_LEVEL];
   logic signed [gwps_pkg::POS_W-1:0] hx_in [MAX_LEVEL];
   logic signed [gwps_pkg::POS_W-1:0] hy_in [MAX_LEVEL];

   // Next line contents
   always_comb begin
      for (int i = 0; i < MAX_LEVEL; i++) begin
         case (ctrl.op)
            gwps_pkg::HIST_FILL: begin
               hx_in[i] = in_x;
               hy_in[i] = in_y;
            end
            gwps_pkg::HIST_PUSH: begin
               hx_in[i] = (i == 0) ? in_x : hx_ff[(i + MAX_LEVEL - 1) % MAX_LEVEL];
               hy_in[i] = (i == 0) ? in_y : hy_ff[(i + MAX_LEVEL - 1) % MAX_LEVEL];
            end
            gwps_pkg::HIST_ROTATE: begin
               hx_in[i] = hx_ff[(i + 1) % MAX_LEVEL];
               hy_in[i] = hy_ff[(i + 1) % MAX_LEVEL];
            end
            default: begin
               hx_in[i] = hx_ff[i];
               hy_in[i] = hy_ff[i];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_LEVEL; i++) begin
            hx_ff[i] <= '0;
            hy_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < MAX_LEVEL; i++) begin
            hx_ff[i] <= hx_in[i];
            hy_ff[i] <= hy_in[i];
         end
      end
   end

   assign head_x = hx_ff[0];
   assign head_y = hy_ff[0];

endmodule

// ----- rtl/gwps_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwps_mac
// Shared multiplier with accumulators: weighted x and y sums, the weight sum,
// and the geometric weight chain, one multiplication per cycle.
// ----------------------------------------------------------------------------
module gwps_mac #(
   parameter int WEIGHT_FRAC_BITS = gwps_pkg::WEIGHT_FRAC_BITS_DEF,
   parameter int WS_W             = 21,
   parameter int AW               = 37
) (
   input  logic                               clock,
   input  logic                               reset,
   input  gwps_pkg::mac_ctrl_type             ctrl,
   input  logic signed [gwps_pkg::POS_W-1:0]  head_x,
   input  logic signed [gwps_pkg::POS_W-1:0]  head_y,
   input  logic        [gwps_pkg::MULT_W-1:0] mult,
   output logic signed [AW-1:0]               acc_x,
   output logic signed [AW-1:0]               acc_y,
   output logic        [WS_W-1:0]             wsum
);

   localparam int W_W = WEIGHT_FRAC_BITS + 1;
   localparam int B_W = gwps_pkg::MULT_W + 1;
   localparam int PW  = W_W + 1 + B_W;
   localparam logic [W_W-1:0] W_ONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};

   logic signed [PW-1:0]  prod_ff, prod_in;
   logic        [W_W-1:0] w_ff, w_in;
   logic signed [AW-1:0]  acc_x_ff, acc_x_in;
   logic signed [AW-1:0]  acc_y_ff, acc_y_in;
   logic        [WS_W-1:0] ws_ff, ws_in;
   logic        [W_W-1:0] w_cur;
   logic        [W_W-1:0] op_a;
   logic signed [B_W-1:0] op_b;

   // Weight of this entry: 1.0 at the head, else the previous ratio product
   assign w_cur = ctrl.first ? W_ONE : prod_ff[gwps_pkg::MUL_FRAC_BITS +: W_W];

   // Operand selection
   always_comb begin
      op_a = (ctrl.op == gwps_pkg::MAC_MUL_X) ? w_cur : w_ff;
      case (ctrl.op)
         gwps_pkg::MAC_MUL_X: op_b = B_W'(head_x);
         gwps_pkg::MAC_MUL_Y: op_b = B_W'(head_y);
         gwps_pkg::MAC_MUL_W: op_b = $signed({1'b0, mult});
         default:             op_b = '0;
      endcase
      prod_in = $signed({1'b0, op_a}) * op_b;
   end

   // Accumulate the product of the previous cycle
   always_comb begin
      acc_x_in = acc_x_ff;
      acc_y_in = acc_y_ff;
      ws_in    = ws_ff;
      w_in     = w_ff;
      if (ctrl.clear) begin
         acc_x_in = '0;
         acc_y_in = '0;
         ws_in    = '0;
      end else begin
         case (ctrl.op)
            gwps_pkg::MAC_MUL_X: begin
               ws_in = ws_ff + WS_W'(w_cur);
               w_in  = w_cur;
            end
            gwps_pkg::MAC_MUL_Y: acc_x_in = acc_x_ff + AW'(prod_ff);
            gwps_pkg::MAC_MUL_W: acc_y_in = acc_y_ff + AW'(prod_ff);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_x_ff <= '0;
         acc_y_ff <= '0;
         ws_ff    <= '0;
      end else begin
         acc_x_ff <= acc_x_in;
         acc_y_ff <= acc_y_in;
         ws_ff    <= ws_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      if (ctrl.op != gwps_pkg::MAC_NOP) begin
         prod_ff <= prod_in;
      end
   end

   assign acc_x = acc_x_ff;
   assign acc_y = acc_y_ff;
   assign wsum  = ws_ff;

endmodule

// ----- rtl/gwps_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwps_div
// Restoring divider, one quotient bit per cycle. Signed dividend, positive
// divisor, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module gwps_div #(
   parameter int WS_W = 21,
   parameter int AW   = 37
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [AW-1:0]              dividend,
   input  logic        [WS_W-1:0]            divisor,
   output logic                              done,
   output logic signed [gwps_pkg::QUO_W-1:0] quotient
);

   localparam int QW  = gwps_pkg::QUO_W;
   localparam int CNW = $clog2(QW);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNW-1:0]  cnt_ff, cnt_in;
   logic [WS_W-1:0] rem_ff, rem_in;
   logic [QW-1:0]   low_ff, low_in;
   logic [QW-1:0]   quo_ff, quo_in;
   logic            neg_ff, neg_in;
   logic [WS_W-1:0] dvs_ff, dvs_in;
   logic [AW-1:0]   mag;
   logic [WS_W:0]   trial;
   logic [WS_W:0]   diff;
   logic            ge;

   assign mag   = dividend[AW-1] ? $unsigned(-dividend) : $unsigned(dividend);
   assign trial = {rem_ff, low_ff[QW-1]};
   assign ge    = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   // Load, then shift one dividend bit in per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNW'(QW - 1);
         rem_in  = mag[QW +: WS_W];
         low_in  = mag[QW-1:0];
         quo_in  = '0;
         neg_in  = dividend[AW-1];
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[WS_W-1:0] : trial[WS_W-1:0];
         low_in = {low_ff[QW-2:0], 1'b0};
         quo_in = {quo_ff[QW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? $signed(-quo_ff) : $signed(quo_ff);

`ifndef SYNTHESIS
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < dvs_ff))
      else $error("partial remainder not below divisor");
`endif

endmodule

// ----- rtl/geometric_weighted_position_smoother.sv -----
`timescale 1ns / 1ps
// Sequence after an accepted request: bypass goes straight to the output state; touch
//   and release walk the entries of the used level on the shared multiplier (three
//   multiplications per entry), finish the history turn, then divide each axis in the bit-serial divider.
// Requests are taken only in the idle state; a held response stalls the next output.
// Reset: synchronous, active high; registers take their reset values and the
//   history and last position clear to zero.
// ----------------------------------------------------------------------------
// geometric_weighted_position_smoother
// Touch-pad position smoother: geometrically weighted window average, with
// distance filter, release handling and bypass.
// ----------------------------------------------------------------------------
module geometric_weighted_position_smoother #(
   parameter int MAX_LEVEL        = gwps_pkg::MAX_LEVEL_DEF,
   parameter int WEIGHT_FRAC_BITS = gwps_pkg::WEIGHT_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [31:0]                        req_tdata,   // pos_x, pos_y
   input  logic [gwps_pkg::MODE_W-1:0]        req_tuser,   // mode
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [31:0]                        rsp_tdata,   // out_x, out_y
   // register writes
   input  logic                               csr_we,
   input  logic [gwps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gwps_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int POS_W = gwps_pkg::POS_W;
   localparam int DW    = gwps_pkg::DIFF_W;
   localparam int W_W   = WEIGHT_FRAC_BITS + 1;
   localparam int PW    = W_W + 1 + gwps_pkg::MULT_W + 1;
   localparam int WS_W  = WEIGHT_FRAC_BITS + $clog2(MAX_LEVEL) + 1;
   localparam int AW    = (PW > WS_W + gwps_pkg::QUO_W) ? PW : WS_W + gwps_pkg::QUO_W;
   localparam int CW    = $clog2(MAX_LEVEL + 1);

   // Sequencer states
   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_WALK       = 4'd1;
   localparam logic [3:0] S_SKIP       = 4'd2;
   localparam logic [3:0] S_DIVX_START = 4'd3;
   localparam logic [3:0] S_DIVX_WAIT  = 4'd4;
   localparam logic [3:0] S_DIVY_START = 4'd5;
   localparam logic [3:0] S_DIVY_WAIT  = 4'd6;
   localparam logic [3:0] S_DIFF       = 4'd7;
   localparam logic [3:0] S_DIST       = 4'd8;
   localparam logic [3:0] S_OUT        = 4'd9;

   // Walk phases per entry
   localparam logic [1:0] PH_X = 2'd0;
   localparam logic [1:0] PH_Y = 2'd1;
   localparam logic [1:0] PH_W = 2'd2;

   logic [3:0]                        state_ff, state_in;
   logic [1:0]                        phase_ff, phase_in;
   logic [CW-1:0]                     k_ff, k_in;
   logic [gwps_pkg::MODE_W-1:0]       mode_ff, mode_in;
   logic [gwps_pkg::LEVEL_W-1:0]      level_ff, level_in;
   logic [gwps_pkg::MULT_W-1:0]       mult_ff, mult_in;
   logic [gwps_pkg::FILTER_W-1:0]     filter_ff, filter_in;
   logic signed [POS_W-1:0]           last_x_ff, last_x_in;
   logic signed [POS_W-1:0]           last_y_ff, last_y_in;
   logic                              emit_ff, emit_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [31:0]                       rsp_data_ff, rsp_data_in;
   logic signed [POS_W-1:0]           ax_ff, ax_in;
   logic signed [POS_W-1:0]           ay_ff, ay_in;
   logic signed [POS_W-1:0]           res_x_ff, res_x_in;
   logic signed [POS_W-1:0]           res_y_ff, res_y_in;
   logic signed [DW-1:0]              dx_ff, dx_in;
   logic signed [DW-1:0]              dy_ff, dy_in;

   logic                              accept;
   logic [gwps_pkg::MODE_W-1:0]       req_mode;
   logic signed [POS_W-1:0]           req_x;
   logic signed [POS_W-1:0]           req_y;
   logic [CW-1:0]                     n_used;
   logic [CW-1:0]                     n_last;
   logic [gwps_pkg::MULT_W-1:0]       mult_sat;
   logic [DW-1:0]                     abs_x;
   logic [DW-1:0]                     abs_y;
   logic [DW:0]                       distance;

   gwps_pkg::mac_ctrl_type            mac_ctrl;
   gwps_pkg::hist_ctrl_type           hist_ctrl;
   logic signed [POS_W-1:0]           head_x;
   logic signed [POS_W-1:0]           head_y;
   logic signed [AW-1:0]              acc_x;
   logic signed [AW-1:0]              acc_y;
   logic [WS_W-1:0]                   wsum;
   logic                              div_start;
   logic signed [AW-1:0]              div_dividend;
   logic                              div_done;
   logic signed [gwps_pkg::QUO_W-1:0] div_quo;

   assign req_mode = req_tuser;
   assign req_x    = $signed(req_tdata[POS_W-1:0]);
   assign req_y    = $signed(req_tdata[2*POS_W-1:POS_W]);
   assign accept   = req_tvalid && req_tready;

   // Level clamp and ratio saturation
   always_comb begin
      if (level_ff == '0) begin
         n_used = CW'(1);
      end else if (32'(level_ff) > MAX_LEVEL) begin
         n_used = CW'(MAX_LEVEL);
      end else begin
         n_used = CW'(level_ff);
      end
      n_last   = n_used - 1'b1;
      mult_sat = (mult_ff > gwps_pkg::MULT_ONE) ? gwps_pkg::MULT_ONE : mult_ff;
   end

   // Manhattan distance to the previous average
   assign abs_x    = dx_ff[DW-1] ? $unsigned(-dx_ff) : $unsigned(dx_ff);
   assign abs_y    = dy_ff[DW-1] ? $unsigned(-dy_ff) : $unsigned(dy_ff);
   assign distance = (DW+1)'(abs_x) + (DW+1)'(abs_y);

   assign div_dividend = (state_ff == S_DIVY_START) ? acc_y : acc_x;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      k_in         = k_ff;
      mode_in      = mode_ff;
      level_in     = level_ff;
      mult_in      = mult_ff;
      filter_in    = filter_ff;
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      emit_in      = emit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      mac_ctrl     = '{clear: 1'b0, first: 1'b0, op: gwps_pkg::MAC_NOP};
      hist_ctrl    = '{op: gwps_pkg::HIST_HOLD};
      div_start    = 1'b0;

      // register writes
      if (csr_we) begin
         case (csr_index)
            gwps_pkg::CSR_LEVEL:      level_in  = csr_wdata[gwps_pkg::LEVEL_W-1:0];
            gwps_pkg::CSR_MULTIPLIER: mult_in   = csr_wdata[gwps_pkg::MULT_W-1:0];
            gwps_pkg::CSR_FILTER:     filter_in = csr_wdata[gwps_pkg::FILTER_W-1:0];
            default: ;
         endcase
      end

      // response taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in = req_mode;
               case (req_mode)
                  gwps_pkg::MODE_BYPASS: begin
                     res_x_in = req_x;
                     res_y_in = req_y;
                     emit_in  = 1'b1;
                     state_in = S_OUT;
                  end
                  gwps_pkg::MODE_TOUCH: begin
                     hist_ctrl.op = (last_x_ff == '0 && last_y_ff == '0) ?
                                    gwps_pkg::HIST_FILL : gwps_pkg::HIST_PUSH;
                     mac_ctrl.clear = 1'b1;
                     k_in     = '0;
                     phase_in = PH_X;
                     state_in = S_WALK;
                  end
                  gwps_pkg::MODE_RELEASE: begin
                     mac_ctrl.clear = 1'b1;
                     k_in     = '0;
                     phase_in = PH_X;
                     state_in = S_WALK;
                  end
                  default: ;
               endcase
            end
         end

         // three multiplications per averaged entry
         S_WALK: begin
            case (phase_ff)
               PH_X: begin
                  mac_ctrl.op    = gwps_pkg::MAC_MUL_X;
                  mac_ctrl.first = (k_ff == '0);
                  phase_in       = PH_Y;
               end
               PH_Y: begin
                  mac_ctrl.op = gwps_pkg::MAC_MUL_Y;
                  phase_in    = PH_W;
               end
               PH_W: begin
                  mac_ctrl.op  = gwps_pkg::MAC_MUL_W;
                  hist_ctrl.op = gwps_pkg::HIST_ROTATE;
                  k_in         = k_ff + 1'b1;
                  phase_in     = PH_X;
                  if (k_ff == n_last) begin
                     state_in = (n_used == CW'(MAX_LEVEL)) ? S_DIVX_START : S_SKIP;
                  end
               end
               default: phase_in = PH_X;
            endcase
         end

         // finish the turn so the history is back in order
         S_SKIP: begin
            hist_ctrl.op = gwps_pkg::HIST_ROTATE;
            k_in         = k_ff + 1'b1;
            if (k_ff == CW'(MAX_LEVEL - 1)) begin
               state_in = S_DIVX_START;
            end
         end

         S_DIVX_START: begin
            div_start = 1'b1;
            state_in  = S_DIVX_WAIT;
         end

         S_DIVX_WAIT: begin
            if (div_done) begin
               ax_in    = div_quo;
               state_in = S_DIVY_START;
            end
         end

         S_DIVY_START: begin
            div_start = 1'b1;
            state_in  = S_DIVY_WAIT;
         end

         S_DIVY_WAIT: begin
            if (div_done) begin
               ay_in = div_quo;
               if (mode_ff == gwps_pkg::MODE_RELEASE) begin
                  res_x_in  = ax_ff;
                  res_y_in  = div_quo;
                  emit_in   = 1'b1;
                  last_x_in = '0;
                  last_y_in = '0;
                  state_in  = S_OUT;
               end else begin
                  state_in = S_DIFF;
               end
            end
         end

         S_DIFF: begin
            dx_in    = DW'(last_x_ff) - DW'(ax_ff);
            dy_in    = DW'(last_y_ff) - DW'(ay_ff);
            state_in = S_DIST;
         end

         S_DIST: begin
            emit_in   = distance > (DW+1)'(filter_ff);
            res_x_in  = ax_ff;
            res_y_in  = ay_ff;
            last_x_in = ax_ff;
            last_y_in = ay_ff;
            state_in  = S_OUT;
         end

         // hand the result to the output register once it is free, or drop it if filtered
         S_OUT: begin
            if (!emit_ff) begin
               state_in = S_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_y_ff, res_x_ff};
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_X;
         k_ff         <= '0;
         mode_ff      <= gwps_pkg::MODE_BYPASS;
         level_ff     <= gwps_pkg::LEVEL_RESET;
         mult_ff      <= gwps_pkg::MULT_RESET;
         filter_ff    <= gwps_pkg::FILTER_RESET;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         emit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         k_ff         <= k_in;
         mode_ff      <= mode_in;
         level_ff     <= level_in;
         mult_ff      <= mult_in;
         filter_ff    <= filter_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      res_x_ff    <= res_x_in;
      res_y_ff    <= res_y_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
   end

   gwps_hist #(
      .MAX_LEVEL (MAX_LEVEL)
   ) u_hist (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (hist_ctrl),
      .in_x   (req_x),
      .in_y   (req_y),
      .head_x (head_x),
      .head_y (head_y)
   );

   gwps_mac #(
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
      .WS_W             (WS_W),
      .AW               (AW)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .head_x (head_x),
      .head_y (head_y),
      .mult   (mult_sat),
      .acc_x  (acc_x),
      .acc_y  (acc_y),
      .wsum   (wsum)
   );

   gwps_div #(
      .WS_W (WS_W),
      .AW   (AW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (wsum),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_walk_start: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_mode == gwps_pkg::MODE_TOUCH || req_mode == gwps_pkg::MODE_RELEASE))
      |=> (state_ff == S_WALK && k_ff == '0))
      else $error("touch or release did not start the window walk");

   a_full_turn: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVX_START) |-> (k_ff == CW'(MAX_LEVEL)))
      else $error("history not rotated a full turn before division");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT))
      else $error("response raised outside the output state");
`endif

endmodule
